// ===== rtl/dtf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtf_pkg
// Shared types and constants of the decimal thousands formatter.
// ----------------------------------------------------------------------------
package dtf_pkg;

  localparam int VALUE_W     = 31;
  localparam int BIN_W       = 32;
  localparam int STEP_BITS   = 4;
  localparam int CONV_STEPS  = BIN_W / STEP_BITS;
  localparam int STEP_W      = $clog2(CONV_STEPS);
  localparam int DIGITS      = 10;
  localparam int DIGIT_W     = 4;
  localparam int BCD_W       = DIGITS * DIGIT_W;
  localparam int IDX_W       = 4;
  localparam int REM_W       = 5;
  localparam int CHAR_W      = 8;
  localparam int MAX_RESULTS = 13;

  localparam logic [CHAR_W-1:0] SEP_RESET  = 8'd46;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;

  typedef struct packed {
    logic load;
    logic conv;
    logic scan;
    logic emit;
  } dtf_cmd_t;

  typedef struct packed {
    logic conv_last;
    logic visible;
    logic slot_free;
    logic rem_one;
  } dtf_stat_t;

endpackage
`default_nettype wire

// ===== rtl/decimal_thousands_formatter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_thousands_formatter
// Formats a non-negative 31-bit integer as grouped decimal ASCII text.
// ----------------------------------------------------------------------------
// Each request carries one value; the block answers with its decimal digits
// as ASCII, most significant first, leading zeros suppressed, with the
// programmable separator (reset value '.') placed between groups of
// GROUP_DIGITS digits counted from the right. Zero gives a single '0'. The
// final character of each number has last_char_o set. A request passes through
// an accept state, binary-to-BCD conversion (four bits per cycle through the
// double-dabble unit), a scan that locates the leading digit and then the
// emission of its characters one after another, which waits on a stalled
// output side for the characters that are sent. The next value is taken once
// the last character of the previous one has entered the output register. If
// a small group size makes the string longer than thirteen characters, only
// the last thirteen are sent.
// ----------------------------------------------------------------------------
module decimal_thousands_formatter
  import dtf_pkg::*;
#(
  parameter int GROUP_DIGITS = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [VALUE_W-1:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CHAR_W-1:0]  out_char_o,
  output logic               last_char_o,
  input  logic               cfg_we_i,
  input  logic [CHAR_W-1:0]  cfg_wdata_i
);

  dtf_cmd_t  cmd;
  dtf_stat_t stat;

  // The sequencer owns the request handshake and issues at most one command a cycle.
  dtf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // The datapath holds the value, its digits, the separator and the result slot.
  dtf_datapath #(
    .GROUP_DIGITS (GROUP_DIGITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .value_i     (value_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_char_o  (out_char_o),
    .last_char_o (last_char_o)
  );

endmodule
`default_nettype wire

// ===== rtl/dtf_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtf_ctrl
// Sequencer: accept, binary to BCD conversion, digit scan, character emission.
// ----------------------------------------------------------------------------
module dtf_ctrl
  import dtf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dtf_stat_t stat_i,
  output dtf_cmd_t  cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state_q, state_d;
  logic       advance;

  // A character step may proceed when it is hidden or the output slot is free.
  assign advance = !stat_i.visible || stat_i.slot_free;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.conv = 1'b1;
        if (stat_i.conv_last) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (advance) begin
          cmd_o.emit = 1'b1;
          if (stat_i.rem_one) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dtf_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtf_datapath
// Double-dabble converter, digit walker, separator register and output slot.
// ----------------------------------------------------------------------------
module dtf_datapath
  import dtf_pkg::*;
#(
  parameter int GROUP_DIGITS = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dtf_cmd_t          cmd_i,
  output dtf_stat_t         stat_o,
  input  logic [VALUE_W-1:0] value_i,
  input  logic              cfg_we_i,
  input  logic [CHAR_W-1:0] cfg_wdata_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [CHAR_W-1:0] out_char_o,
  output logic              last_char_o
);

  localparam int G = (GROUP_DIGITS < 1) ? 1 : GROUP_DIGITS;

  typedef logic [REM_W-1:0] rem_tab_t [DIGITS];
  typedef logic [IDX_W-1:0] idx_tab_t [DIGITS];

  // Total string length for a given top digit index.
  function automatic rem_tab_t f_total_tab();
    rem_tab_t t;
    for (int i = 0; i < DIGITS; i++) begin
      t[i] = REM_W'(i + 1 + i / G);
    end
    return t;
  endfunction

  // Position within its group of a given top digit index.
  function automatic idx_tab_t f_phase_tab();
    idx_tab_t t;
    for (int i = 0; i < DIGITS; i++) begin
      t[i] = IDX_W'(i % G);
    end
    return t;
  endfunction

  localparam rem_tab_t TOTAL_TAB = f_total_tab();
  localparam idx_tab_t PHASE_TAB = f_phase_tab();

  logic [CHAR_W-1:0] sep_q;
  logic [BIN_W-1:0]  bin_q, bin_d;
  logic [BCD_W-1:0]  bcd_q, bcd_d;
  logic [STEP_W-1:0] step_q;
  logic [IDX_W-1:0]  dig_q, top_idx;
  logic [IDX_W-1:0]  phase_q;
  logic [REM_W-1:0]  rem_q;
  logic              sep_pend_q;
  logic              out_valid_q;
  logic [CHAR_W-1:0] out_char_q;
  logic              last_q;
  logic [DIGIT_W-1:0] cur_digit;
  logic [CHAR_W-1:0] cur_char;
  logic              visible;

  // Four shift-and-adjust iterations per cycle.
  always_comb begin
    logic [BCD_W-1:0] b;
    logic [BIN_W-1:0] r;
    b = bcd_q;
    r = bin_q;
    for (int k = 0; k < STEP_BITS; k++) begin
      for (int j = 0; j < DIGITS; j++) begin
        if (b[j*DIGIT_W +: DIGIT_W] >= 4'd5) begin
          b[j*DIGIT_W +: DIGIT_W] = b[j*DIGIT_W +: DIGIT_W] + 4'd3;
        end
      end
      {b, r} = {b[BCD_W-2:0], r, 1'b0};
    end
    bcd_d = b;
    bin_d = r;
  end

  // Index of the most significant nonzero digit; zero gives index 0.
  always_comb begin
    top_idx = '0;
    for (int j = 1; j < DIGITS; j++) begin
      if (bcd_q[j*DIGIT_W +: DIGIT_W] != '0) begin
        top_idx = IDX_W'(j);
      end
    end
  end

  assign cur_digit = bcd_q[dig_q*DIGIT_W +: DIGIT_W];
  assign cur_char  = sep_pend_q ? sep_q : (ASCII_ZERO + {4'b0000, cur_digit});
  assign visible   = (rem_q <= REM_W'(MAX_RESULTS));

  assign stat_o.conv_last = (step_q == STEP_W'(CONV_STEPS - 1));
  assign stat_o.visible   = visible;
  assign stat_o.slot_free = !out_valid_q || !out_stall_i;
  assign stat_o.rem_one   = (rem_q == REM_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q <= SEP_RESET;
    end else if (cfg_we_i) begin
      sep_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= '0;
      sep_pend_q <= 1'b0;
      rem_q      <= '0;
    end else begin
      if (cmd_i.load) begin
        step_q <= '0;
      end else if (cmd_i.conv) begin
        step_q <= step_q + 1'b1;
      end
      if (cmd_i.scan) begin
        rem_q      <= TOTAL_TAB[top_idx];
        sep_pend_q <= 1'b0;
      end else if (cmd_i.emit) begin
        rem_q <= rem_q - 1'b1;
        if (sep_pend_q) begin
          sep_pend_q <= 1'b0;
        end else begin
          sep_pend_q <= (phase_q == '0) && (dig_q != '0);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bin_q <= {1'b0, value_i};
      bcd_q <= '0;
    end else if (cmd_i.conv) begin
      bin_q <= bin_d;
      bcd_q <= bcd_d;
    end
    if (cmd_i.scan) begin
      dig_q   <= top_idx;
      phase_q <= PHASE_TAB[top_idx];
    end else if (cmd_i.emit && !sep_pend_q && (dig_q != '0)) begin
      dig_q   <= dig_q - 1'b1;
      phase_q <= (phase_q == '0) ? IDX_W'(G - 1) : phase_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit && visible) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit && visible) begin
      out_char_q <= cur_char;
      last_q     <= (rem_q == REM_W'(1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_char_o = last_q;

`ifndef SYNTHESIS
  // A separator is always followed by at least one more digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && sep_pend_q) |-> (dig_q != '0))
    else $error("separator emitted with no digit left");

  // The final character of a number is its units digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && (rem_q == REM_W'(1))) |-> (!sep_pend_q && (dig_q == '0)))
    else $error("final character is not the units digit");

  // The scan always yields a nonempty string.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |=> (rem_q != '0))
    else $error("empty character count after scan");
`endif

endmodule
`default_nettype wire
